// ===== hdl/static_linked_list_engine_assert.svh =====
`ifndef STATIC_LINKED_LIST_ENGINE_ASSERT_SVH
`define STATIC_LINKED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sll_pkg.sv =====
package sll_pkg;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int SLOT_W = 7;
    localparam int LEN_W  = 7;

    localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_FREE = 2'd2;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [VAL_W-1:0]  read_value;
        logic [SLOT_W-1:0]        slot;
        logic [LEN_W-1:0]         length;
    } t_rsp;

endpackage

// ===== hdl/sll_cmd_if.sv =====
interface sll_cmd_if import sll_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

// ===== hdl/sll_rsp_if.sv =====
interface sll_rsp_if import sll_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] read_value;
    logic [SLOT_W-1:0]       slot;
    logic [LEN_W-1:0]        length;

    modport source (output valid, output status, output read_value, output slot,
                    output length, input ready);
    modport sink   (input valid, input status, input read_value, input slot,
                    input length, output ready);
endinterface

// ===== hdl/sll_ram.sv =====
module sll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sll_rsp_reg.sv =====
module sll_rsp_reg import sll_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rsp i_data,
    output logic o_free,
    sll_rsp_if.source o_rsp
);

    logic r_valid;
    t_rsp r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_data;
        end
    end

    assign o_free           = !r_valid || o_rsp.ready;
    assign o_rsp.valid      = r_valid;
    assign o_rsp.status     = r_data.status;
    assign o_rsp.read_value = r_data.read_value;
    assign o_rsp.slot       = r_data.slot;
    assign o_rsp.length     = r_data.length;

endmodule

// ===== hdl/static_linked_list_engine.sv =====
// Linked list engine over a node array with a free list.
// Channels: i_cmd takes one command transaction (command, position, value);
// o_rsp returns exactly one response transaction per command (status,
// read_value, slot, length), in command order.
// One command is in work at a time; i_cmd.ready is high only while the
// sequencer is idle. The response sits in an output register, so the next
// command is taken while an earlier response still waits on o_rsp.
// A read, write, insert or delete walks the list from the head through the
// link memory read port, which follows one next link per cycle; a rejected
// or unknown command goes straight to the response.
// Reset starts a sweep over all NODES entries that rebuilds the link chains in the
// link memory; i_cmd.ready stays low until it finishes. A clear runs the same
// sweep. Node values are not initialized and are kept across clear.
// If o_rsp stalls, a finished command waits in its last state until the
// output register frees; nothing is dropped.
module static_linked_list_engine import sll_pkg::*; #(
    parameter int NODES = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sll_cmd_if.sink   i_cmd,
    sll_rsp_if.source o_rsp
);

    localparam int IW   = $clog2(NODES);
    localparam int CMPW = ((IW > POS_W) ? IW : POS_W) + 1;
    localparam logic [IW-1:0] LIST_HEAD  = '0;
    localparam logic [IW-1:0] FREE_HEAD  = IW'(1);
    localparam logic [IW-1:0] FIRST_NODE = IW'(2);
    localparam logic [IW-1:0] LAST_NODE  = IW'(NODES - 1);
    localparam logic [IW-1:0] FREE_INIT  = IW'(NODES - 2);

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_WALK, S_RCAP,
        S_INS1, S_INS2, S_INS3, S_INS4,
        S_DEL1, S_DEL2, S_DEL3, S_DEL4,
        S_DONE
    } t_state;

    t_state                  r_state;
    logic [CMD_W-1:0]        r_cmd;
    logic signed [VAL_W-1:0] r_val;
    logic [POS_W-1:0]        r_steps;
    logic [IW-1:0]           r_k;
    logic [IW-1:0]           r_j;
    logic [IW-1:0]           r_nk;
    logic                    r_rdv;
    logic [IW-1:0]           r_cnt;
    logic [IW-1:0]           r_fcnt;
    logic [IW-1:0]           r_addr;
    logic                    r_sweep_rsp;
    logic [ST_W-1:0]         r_status;
    logic signed [VAL_W-1:0] r_rval;
    logic [SLOT_W-1:0]       r_slot;

    logic             lk_we, lk_re;
    logic [IW-1:0]    lk_waddr, lk_wdata, lk_raddr, lk_rdata;
    logic             vl_we, vl_re;
    logic [IW-1:0]    vl_waddr, vl_raddr;
    logic [VAL_W-1:0] vl_wdata, vl_rdata;

    logic [IW-1:0]   cur_node;
    logic [IW-1:0]   init_link;
    logic [CMPW-1:0] pos_x, cnt_x;
    logic            pos_in_list, pos_in_ins;
    logic            rsp_free, rsp_push;
    t_rsp            rsp_data;

    sll_ram #(.WIDTH(IW), .DEPTH(NODES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_re    (lk_re),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    sll_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (vl_we),
        .i_waddr (vl_waddr),
        .i_wdata (vl_wdata),
        .i_re    (vl_re),
        .i_raddr (vl_raddr),
        .o_rdata (vl_rdata)
    );

    sll_rsp_reg u_rsp_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rsp_push),
        .i_data  (rsp_data),
        .o_free  (rsp_free),
        .o_rsp   (o_rsp)
    );

    // During a walk the node just reached comes straight from the link RAM.
    assign cur_node = r_rdv ? lk_rdata : r_k;

    assign pos_x       = CMPW'(i_cmd.position);
    assign cnt_x       = CMPW'(r_cnt);
    assign pos_in_list = (i_cmd.position != '0) && (pos_x <= cnt_x);
    assign pos_in_ins  = (i_cmd.position != '0) && (pos_x <= cnt_x + CMPW'(1));

    assign i_cmd.ready = (r_state == S_IDLE);
    assign rsp_push    = (r_state == S_DONE) && rsp_free;
    assign rsp_data    = '{status:     r_status,
                           read_value: r_rval,
                           slot:       r_slot,
                           length:     LEN_W'(r_cnt)};

    always_comb begin
        if (r_addr == LIST_HEAD || r_addr == LAST_NODE) begin
            init_link = '0;
        end else if (r_addr == FREE_HEAD) begin
            init_link = FIRST_NODE;
        end else begin
            init_link = r_addr + IW'(1);
        end
    end

    always_comb begin
        lk_we    = 1'b0;
        lk_waddr = '0;
        lk_wdata = '0;
        lk_re    = 1'b0;
        lk_raddr = '0;
        vl_we    = 1'b0;
        vl_waddr = '0;
        vl_wdata = '0;
        vl_re    = 1'b0;
        vl_raddr = '0;
        case (r_state)
            S_SWEEP: begin
                lk_we    = 1'b1;
                lk_waddr = r_addr;
                lk_wdata = init_link;
            end
            S_WALK: begin
                if (r_steps == '0) begin
                    case (r_cmd)
                        CMD_READ: begin
                            vl_re    = 1'b1;
                            vl_raddr = cur_node;
                        end
                        CMD_WRITE: begin
                            vl_we    = 1'b1;
                            vl_waddr = cur_node;
                            vl_wdata = r_val;
                        end
                        CMD_INSERT, CMD_DELETE: begin
                            lk_re    = 1'b1;
                            lk_raddr = cur_node;
                        end
                        default: ;
                    endcase
                end else begin
                    lk_re    = 1'b1;
                    lk_raddr = cur_node;
                end
            end
            S_INS1: begin
                lk_re    = 1'b1;
                lk_raddr = FREE_HEAD;
            end
            S_INS2: begin
                // lk_rdata is the popped free node
                lk_re    = 1'b1;
                lk_raddr = lk_rdata;
                lk_we    = 1'b1;
                lk_waddr = r_k;
                lk_wdata = lk_rdata;
                vl_we    = 1'b1;
                vl_waddr = lk_rdata;
                vl_wdata = r_val;
            end
            S_INS3: begin
                lk_we    = 1'b1;
                lk_waddr = FREE_HEAD;
                lk_wdata = lk_rdata;
            end
            S_INS4: begin
                lk_we    = 1'b1;
                lk_waddr = r_j;
                lk_wdata = r_nk;
            end
            S_DEL1: begin
                // lk_rdata is the node being removed
                lk_re    = 1'b1;
                lk_raddr = lk_rdata;
                vl_re    = 1'b1;
                vl_raddr = lk_rdata;
            end
            S_DEL2: begin
                lk_we    = 1'b1;
                lk_waddr = r_k;
                lk_wdata = lk_rdata;
                lk_re    = 1'b1;
                lk_raddr = FREE_HEAD;
            end
            S_DEL3: begin
                lk_we    = 1'b1;
                lk_waddr = r_j;
                lk_wdata = lk_rdata;
            end
            S_DEL4: begin
                lk_we    = 1'b1;
                lk_waddr = FREE_HEAD;
                lk_wdata = r_j;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_addr      <= '0;
            r_sweep_rsp <= 1'b0;
            r_cnt       <= '0;
            r_fcnt      <= FREE_INIT;
            r_rdv       <= 1'b0;
        end else begin
            case (r_state)
                S_SWEEP: begin
                    if (r_addr == LAST_NODE) begin
                        r_cnt   <= '0;
                        r_fcnt  <= FREE_INIT;
                        r_state <= r_sweep_rsp ? S_DONE : S_IDLE;
                    end else begin
                        r_addr <= r_addr + IW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd    <= i_cmd.command;
                        r_val    <= i_cmd.value;
                        r_k      <= LIST_HEAD;
                        r_rdv    <= 1'b0;
                        r_status <= ST_OK;
                        r_rval   <= '0;
                        r_slot   <= '0;
                        r_state  <= S_DONE;
                        case (i_cmd.command)
                            CMD_READ, CMD_WRITE: begin
                                if (pos_in_list) begin
                                    r_steps <= i_cmd.position;
                                    r_state <= S_WALK;
                                end else begin
                                    r_status <= ST_BAD_POS;
                                end
                            end
                            CMD_INSERT: begin
                                if (!pos_in_ins) begin
                                    r_status <= ST_BAD_POS;
                                end else if (r_fcnt == '0) begin
                                    r_status <= ST_NO_FREE;
                                end else begin
                                    r_steps <= i_cmd.position - POS_W'(1);
                                    r_state <= S_WALK;
                                end
                            end
                            CMD_DELETE: begin
                                if (pos_in_list) begin
                                    r_steps <= i_cmd.position - POS_W'(1);
                                    r_state <= S_WALK;
                                end else begin
                                    r_status <= ST_BAD_POS;
                                end
                            end
                            CMD_CLEAR: begin
                                r_addr      <= '0;
                                r_sweep_rsp <= 1'b1;
                                r_state     <= S_SWEEP;
                            end
                            default: ;
                        endcase
                    end
                end
                S_WALK: begin
                    if (r_steps == '0) begin
                        r_k   <= cur_node;
                        r_rdv <= 1'b0;
                        case (r_cmd)
                            CMD_READ: begin
                                r_slot  <= SLOT_W'(cur_node);
                                r_state <= S_RCAP;
                            end
                            CMD_INSERT: r_state <= S_INS1;
                            CMD_DELETE: r_state <= S_DEL1;
                            default:    r_state <= S_DONE;
                        endcase
                    end else begin
                        r_steps <= r_steps - POS_W'(1);
                        r_rdv   <= 1'b1;
                    end
                end
                S_RCAP: begin
                    r_rval  <= vl_rdata;
                    r_state <= S_DONE;
                end
                S_INS1: begin
                    r_nk    <= lk_rdata;
                    r_state <= S_INS2;
                end
                S_INS2: begin
                    r_j     <= lk_rdata;
                    r_state <= S_INS3;
                end
                S_INS3: begin
                    r_state <= S_INS4;
                end
                S_INS4: begin
                    r_cnt   <= r_cnt + IW'(1);
                    r_fcnt  <= r_fcnt - IW'(1);
                    r_state <= S_DONE;
                end
                S_DEL1: begin
                    r_j     <= lk_rdata;
                    r_state <= S_DEL2;
                end
                S_DEL2: begin
                    r_rval  <= vl_rdata;
                    r_state <= S_DEL3;
                end
                S_DEL3: begin
                    r_state <= S_DEL4;
                end
                S_DEL4: begin
                    r_cnt   <= r_cnt - IW'(1);
                    r_fcnt  <= r_fcnt + IW'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (rsp_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/sll_checker.sv =====
`include "static_linked_list_engine_assert.svh"

module sll_checker import sll_pkg::*; #(
    parameter int NODES = 128
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_cmd_valid,
    input logic                    i_cmd_ready,
    input logic                    i_rsp_valid,
    input logic                    i_rsp_ready,
    input logic [ST_W-1:0]         i_status,
    input logic signed [VAL_W-1:0] i_read_value,
    input logic [SLOT_W-1:0]       i_slot,
    input logic [LEN_W-1:0]        i_length
);

    localparam bit LEN_WRAPS = (NODES > 129);
    localparam int LEN_MAX   = NODES - 2;

    `SLL_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid, "response dropped while stalled")

    // One command in work at a time.
    `SLL_ASSERT_NXT(a_one_cmd, i_clk, i_rst_n, i_cmd_valid && i_cmd_ready, !i_cmd_ready, "command taken while another is in work")

    // Failed commands report no value and no node.
    `SLL_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, i_rsp_valid && (i_status != ST_OK), (i_slot == '0) && (i_read_value == '0), "failed command returned data")

    `SLL_ASSERT_NOW(a_len_max, i_clk, i_rst_n, i_rsp_valid, LEN_WRAPS || (int'(i_length) <= LEN_MAX), "length above node capacity")

endmodule

bind static_linked_list_engine sll_checker #(.NODES(NODES)) u_sll_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_read_value (o_rsp.read_value),
    .i_slot       (o_rsp.slot),
    .i_length     (o_rsp.length)
);

// ===== dv/static_linked_list_engine_checker.sv =====
module static_linked_list_engine_checker import sll_pkg::*; #(
    parameter int NODES = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sll_cmd_if   i_cmd,
    sll_rsp_if   i_rsp,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_HEAD = 0;
    localparam int FREE_HEAD = 1;

    logic signed [VAL_W-1:0] node_val  [NODES];
    int                      node_link [NODES];
    int                      list_len;
    int                      free_len;
    int                      err_cnt = 0;
    t_rsp                    rsp_q [$];

    function automatic int walk_to(int steps);
        int k;
        k = LIST_HEAD;
        for (int i = 0; i < steps; i++) k = node_link[k];
        return k;
    endfunction

    task automatic rebuild_chains();
        node_link[LIST_HEAD] = 0;
        node_link[FREE_HEAD] = 2;
        for (int i = 2; i < NODES - 1; i++) node_link[i] = i + 1;
        node_link[NODES-1] = 0;
        list_len = 0;
        free_len = NODES - 2;
    endtask

    // Apply one command to the shadow list and build its response.
    task automatic apply_cmd(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                             input logic [VAL_W-1:0] v, output t_rsp r);
        int pos;
        int k;
        int j;
        pos = int'(p);
        r = '0;
        case (c)
            CMD_READ, CMD_WRITE: begin
                if (pos < 1 || pos > list_len) begin
                    r.status = ST_BAD_POS;
                end else begin
                    k = walk_to(pos);
                    if (c == CMD_READ) begin
                        r.read_value = node_val[k];
                        r.slot       = SLOT_W'(k);
                    end else begin
                        node_val[k] = v;
                    end
                end
            end
            CMD_INSERT: begin
                // position check wins over a full store
                if (pos < 1 || pos > list_len + 1) begin
                    r.status = ST_BAD_POS;
                end else if (free_len == 0) begin
                    r.status = ST_NO_FREE;
                end else begin
                    j = node_link[FREE_HEAD];
                    node_link[FREE_HEAD] = node_link[j];
                    free_len--;
                    node_val[j] = v;
                    k = walk_to(pos - 1);
                    node_link[j] = node_link[k];
                    node_link[k] = j;
                    list_len++;
                end
            end
            CMD_DELETE: begin
                if (pos < 1 || pos > list_len) begin
                    r.status = ST_BAD_POS;
                end else begin
                    k = walk_to(pos - 1);
                    j = node_link[k];
                    node_link[k] = node_link[j];
                    list_len--;
                    node_link[j] = node_link[FREE_HEAD];
                    node_link[FREE_HEAD] = j;
                    free_len++;
                    r.read_value = node_val[j];
                end
            end
            CMD_CLEAR: rebuild_chains();
            default: ;
        endcase
        r.length = LEN_W'(list_len);
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        t_rsp next_rsp;
        if (!i_rst_n) begin
            rebuild_chains();
            rsp_q.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.status     = i_rsp.status;
                got.read_value = i_rsp.read_value;
                got.slot       = i_rsp.slot;
                got.length     = i_rsp.length;
                if (rsp_q.size() == 0) begin
                    $error("response transaction with no command outstanding");
                    err_cnt++;
                end else begin
                    want = rsp_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        err_cnt++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, got.read_value);
                        err_cnt++;
                    end
                    if (got.slot !== want.slot) begin
                        $error("slot: expected %0d, got %0d", want.slot, got.slot);
                        err_cnt++;
                    end
                    if (got.length !== want.length) begin
                        $error("length: expected %0d, got %0d", want.length, got.length);
                        err_cnt++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                apply_cmd(i_cmd.command, i_cmd.position, i_cmd.value, next_rsp);
                rsp_q.push_back(next_rsp);
            end
        end
        o_errors  <= err_cnt;
        o_pending <= rsp_q.size();
    end

endmodule

// ===== dv/static_linked_list_engine_tb.sv =====
module static_linked_list_engine_tb;
    import sll_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES       = 128;
    localparam int MAX_LEN     = NODES - 2;
    localparam int HOLD_LEN    = 600;
    localparam int TAIL_CYCLES = NODES + 16;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_ITEMS = 240;
    localparam int POS_MAX     = (1 << POS_W) - 1;

    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_CLEAR + 3'd1;
    localparam logic [CMD_W-1:0] CMD_UNUSED_MID   = CMD_CLEAR + 3'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sll_cmd_if cmd_if ();
    sll_rsp_if rsp_if ();

    int errors;
    int pending;
    int list_len    = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_tokens = 0;
    int cycles      = 0;

    static_linked_list_engine #(.NODES(NODES)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    static_linked_list_engine_checker #(.NODES(NODES)) u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_if),
        .i_rsp     (rsp_if),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Response side: random backpressure plus an on-demand long hold-off.
    initial begin
        int hold_left;
        int served;
        hold_left = 0;
        served    = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                rsp_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (served != hold_tokens) begin
                served    = hold_tokens;
                hold_left = HOLD_LEN;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // One command transaction; tracks list length to steer positions.
    task automatic issue(input logic [CMD_W-1:0] c, input int p, input logic [VAL_W-1:0] v);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.command  <= c;
        cmd_if.position <= POS_W'(p);
        cmd_if.value    <= v;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        case (c)
            CMD_INSERT: if (p >= 1 && p <= list_len + 1 && list_len < MAX_LEN) list_len++;
            CMD_DELETE: if (p >= 1 && p <= list_len) list_len--;
            CMD_CLEAR:  list_len = 0;
            default: ;
        endcase
    endtask

    task automatic issue_random(input int w_ins, input int w_del);
        int roll;
        int p;
        logic [CMD_W-1:0] c;
        roll = $urandom_range(99);
        if (roll < 5) begin
            // noise: any code, any position
            c = CMD_W'($urandom_range(CMD_UNUSED_LAST, 0));
            p = $urandom_range(POS_MAX, 0);
        end else begin
            roll = $urandom_range(99);
            if (roll < 1)
                c = CMD_CLEAR;
            else if (roll < 1 + w_ins)
                c = CMD_INSERT;
            else if (roll < 1 + w_ins + w_del)
                c = CMD_DELETE;
            else if (roll < 1 + w_ins + w_del + (99 - w_ins - w_del) / 2)
                c = CMD_READ;
            else
                c = CMD_WRITE;
            if (c == CMD_INSERT)
                p = $urandom_range(list_len + 1, 1);
            else
                p = $urandom_range((list_len > 0) ? list_len : 1, 1);
        end
        issue(c, p, $urandom);
    endtask

    initial begin
        int ins_w [6];
        int del_w [6];
        ins_w = '{40, 30, 45, 15, 35, 25};
        del_w = '{20, 30, 15, 45, 25, 25};

        i_rst_n         <= 1'b0;
        cmd_if.valid    <= 1'b0;
        cmd_if.command  <= CMD_READ;
        cmd_if.position <= '0;
        cmd_if.value    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, extreme values, bad positions, unused codes, clear
        issue(CMD_READ,   1, 32'h0);
        issue(CMD_INSERT, 0, 32'h1);
        issue(CMD_INSERT, 2, 32'h2);
        issue(CMD_INSERT, 1, 32'h7FFF_FFFF);
        issue(CMD_INSERT, 1, 32'h8000_0000);
        issue(CMD_INSERT, 3, 32'h0);
        issue(CMD_INSERT, 2, 32'hFFFF_FFFF);
        issue(CMD_READ,   1, 32'h0);
        issue(CMD_READ,   4, 32'h0);
        issue(CMD_READ,   5, 32'h0);
        issue(CMD_WRITE,  4, 32'h5A5A_A5A5);
        issue(CMD_READ,   4, 32'h0);
        issue(CMD_WRITE,  0, 32'h1234_5678);
        issue(CMD_DELETE, 5, 32'h0);
        issue(CMD_DELETE, 0, 32'h0);
        issue(CMD_DELETE, 2, 32'h0);
        issue(CMD_DELETE, 1, 32'h0);
        issue(CMD_READ,   1, 32'h0);
        issue(CMD_UNUSED_FIRST, 1, 32'hDEAD_BEEF);
        issue(CMD_UNUSED_MID, POS_MAX, 32'hFFFF_FFFF);
        issue(CMD_UNUSED_LAST, 0, 32'h0);
        issue(CMD_READ,   POS_MAX, 32'h0);
        issue(CMD_CLEAR,  0, 32'h0);
        issue(CMD_READ,   1, 32'h0);
        issue(CMD_INSERT, 1, 32'h0000_1234);

        // fill to a full store, then hit the full cases
        idle_pct  = 22;
        stall_pct = 22;
        while (list_len < MAX_LEN) issue(CMD_INSERT, $urandom_range(list_len + 1, 1), $urandom);
        issue(CMD_INSERT, 0, $urandom);
        issue(CMD_INSERT, POS_MAX, $urandom);
        issue(CMD_INSERT, 1, $urandom);
        issue(CMD_READ,   POS_MAX, 32'h0);
        issue(CMD_READ,   MAX_LEN, 32'h0);
        issue(CMD_DELETE, MAX_LEN, 32'h0);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            if (ph == 0) hold_tokens++;
            for (int n = 0; n < PHASE_ITEMS; n++) issue_random(ins_w[ph], del_w[ph]);
        end

        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
